// File: hw/rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the delimiter tokenizer: field widths,
// configuration register indexes, and the item and result records.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int POS_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int DELIM_SLOTS = 4;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 3;

  // Strings longer than this saturate the position counter.
  localparam logic [POS_W-1:0]  MAX_LENGTH = 16'hFFFF;
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

  // Register reset values
  localparam logic [BYTE_W-1:0]  DELIM_A_RESET     = 8'd44;
  localparam logic [BYTE_W-1:0]  DELIM_OTHER_RESET = 8'd0;
  localparam logic [COUNT_W-1:0] DELIM_COUNT_RESET = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_A     = 3'd0,
    REG_DELIM_B     = 3'd1,
    REG_DELIM_C     = 3'd2,
    REG_DELIM_D     = 3'd3,
    REG_DELIM_COUNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DELIM_SLOTS-1:0][BYTE_W-1:0] delim;
    logic [COUNT_W-1:0]                 count;
  } delim_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] char_byte;
    logic              is_final;
  } item_t;

  typedef struct packed {
    logic             token_valid;
    logic [POS_W-1:0] token_start;
    logic [POS_W-1:0] token_length;
    logic             string_end;
    logic             too_long;
  } result_t;

endpackage

// File: hw/rtl/dtt_delim_match.sv
// ----------------------------------------------------------------------------
// dtt_delim_match
// Compare one byte against the delimiter slots that are in use.
// ----------------------------------------------------------------------------
module dtt_delim_match (
  input  dtt_pkg::delim_cfg_t          cfg,
  input  logic [dtt_pkg::BYTE_W-1:0]   char_byte,
  output logic                         is_delim
);

  logic [dtt_pkg::DELIM_SLOTS-1:0] hit;

  // A slot counts when delim_count reaches past it; counts above the slot
  // total enable every slot.
  always_comb begin
    for (int i = 0; i < dtt_pkg::DELIM_SLOTS; i++) begin
      hit[i] = (cfg.count >= dtt_pkg::COUNT_W'(i + 1)) && (char_byte == cfg.delim[i]);
    end
  end

  assign is_delim = |hit;

endmodule

// File: hw/rtl/dtt_token.sv
// ----------------------------------------------------------------------------
// dtt_token
// Token tracking state and the result register. Consume one item per cycle
// unless a result is due and the result register is still full.
// ----------------------------------------------------------------------------
module dtt_token (
  input  logic                 clk,
  input  logic                 rst,
  input  dtt_pkg::delim_cfg_t  cfg,
  input  logic                 item_valid,
  input  dtt_pkg::item_t       item,
  output logic                 take,
  output logic                 res_valid,
  input  logic                 res_ready,
  output dtt_pkg::result_t     res
);

  logic [dtt_pkg::POS_W-1:0] position, position_next;
  logic [dtt_pkg::POS_W-1:0] tok_begin, tok_begin_next;
  logic [dtt_pkg::POS_W-1:0] tok_stop, tok_stop_next;
  logic                      in_token, in_token_next;
  logic                      overflowed, overflowed_next;

  logic                      is_delim;
  logic                      saturated;
  logic                      closed;
  logic                      emits;
  logic [dtt_pkg::POS_W-1:0] close_start;
  logic [dtt_pkg::POS_W-1:0] close_len;
  dtt_pkg::result_t          res_next;

  dtt_delim_match u_match (
    .cfg       (cfg),
    .char_byte (item.char_byte),
    .is_delim  (is_delim)
  );

  assign saturated = (position == dtt_pkg::MAX_LENGTH);

  always_comb begin
    position_next   = position;
    tok_begin_next  = tok_begin;
    tok_stop_next   = tok_stop;
    in_token_next   = in_token;
    overflowed_next = overflowed;
    closed          = 1'b0;
    close_start     = '0;
    close_len       = '0;

    if (saturated) begin
      overflowed_next = 1'b1;
    end else begin
      if (is_delim) begin
        if (in_token) begin
          closed        = 1'b1;
          close_start   = tok_begin;
          close_len     = tok_stop - tok_begin;
          in_token_next = 1'b0;
        end
      end else if (item.char_byte != dtt_pkg::SPACE_BYTE && cfg.count != '0) begin
        if (!in_token) begin
          tok_begin_next = position;
          in_token_next  = 1'b1;
        end
        tok_stop_next = position + 1'b1;
      end
      position_next = position + 1'b1;
    end

    // Final byte flushes a token that is still open.
    if (item.is_final && !closed && in_token_next) begin
      closed      = 1'b1;
      close_start = tok_begin_next;
      close_len   = tok_stop_next - tok_begin_next;
    end

    res_next.token_valid  = closed;
    res_next.token_start  = close_start;
    res_next.token_length = close_len;
    res_next.string_end   = item.is_final;
    res_next.too_long     = overflowed_next;

    if (item.is_final) begin
      position_next   = '0;
      tok_begin_next  = '0;
      tok_stop_next   = '0;
      in_token_next   = 1'b0;
      overflowed_next = 1'b0;
    end
  end

  assign emits = closed || item.is_final;
  assign take  = item_valid && (!res_valid || res_ready || !emits);

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      tok_begin  <= '0;
      tok_stop   <= '0;
      in_token   <= 1'b0;
      overflowed <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (take) begin
        position   <= position_next;
        tok_begin  <= tok_begin_next;
        tok_stop   <= tok_stop_next;
        in_token   <= in_token_next;
        overflowed <= overflowed_next;
      end
      if (take && emits) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emits) begin
      res <= res_next;
    end
  end

`ifndef SYNTH
  a_open_token_nonempty: assert property (@(posedge clk) disable iff (rst)
    in_token |-> (tok_stop > tok_begin))
    else $error("open token has no bytes");

  a_string_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (take && item.is_final) |=> (position == '0 && !in_token && !overflowed))
    else $error("string state not cleared after final byte");

  a_overflow_saturated: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> (position == dtt_pkg::MAX_LENGTH))
    else $error("overflow flag without saturated position");

  a_token_has_length: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.token_valid) |-> (res.token_length != '0))
    else $error("reported token has zero length");

  a_empty_result_zeroed: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.token_valid) |-> (res.token_start == '0 && res.token_length == '0
                                         && res.string_end))
    else $error("result without token is not a clean end marker");
`endif

endmodule

// File: hw/rtl/delimiter_tokenizer_trim_top.sv
// ----------------------------------------------------------------------------
// delimiter_tokenizer_trim_top
// Byte-stream tokenizer: split at configured delimiters, trim spaces.
// ----------------------------------------------------------------------------
// Feed a string one byte per word on the slave stream, with tlast on its
// last byte. The block splits the string at any byte equal to one of the
// first delim_count delimiter registers (delim_count of zero disables
// tokens, values above four act as four), trims spaces (0x20) from both
// ends of each piece and drops pieces that end up empty. Each token comes
// out as one master word holding its start position and trimmed length,
// on the delimiter byte that closes it; the last byte of a string always
// gives one word with tlast set, carrying the final token if one is open
// (tuser[0] low otherwise, start and length zero). Bytes beyond 65535 in a
// string are ignored and tuser[1] (too long) is raised on the following
// words of that string. The block takes one byte per cycle: a byte is
// taken into an input register, passes the compare and token update
// logic, and lands in a result register that drives the master side.
// The byte stream only stalls when a result is due while the result
// register still holds an untaken word. Write the configuration
// registers only while the block is idle; a write lands on the clock
// edge with cfg_we high.
// ----------------------------------------------------------------------------
module delimiter_tokenizer_trim_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [dtt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtt_pkg::BYTE_W-1:0]      cfg_data,
  // byte stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] char_byte
  input  logic                            s_tlast,   // is_final
  // token stream out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [15:0] token_start, [31:16] token_length
  output logic                            m_tlast,   // string_end
  output logic [1:0]                      m_tuser    // [0] token_valid, [1] too_long
);

  dtt_pkg::delim_cfg_t cfg;
  logic                in_valid;
  dtt_pkg::item_t      in_item;
  logic                take;
  dtt_pkg::result_t    res;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim[0] <= dtt_pkg::DELIM_A_RESET;
      cfg.delim[1] <= dtt_pkg::DELIM_OTHER_RESET;
      cfg.delim[2] <= dtt_pkg::DELIM_OTHER_RESET;
      cfg.delim[3] <= dtt_pkg::DELIM_OTHER_RESET;
      cfg.count    <= dtt_pkg::DELIM_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtt_pkg::REG_DELIM_A:     cfg.delim[0] <= cfg_data;
        dtt_pkg::REG_DELIM_B:     cfg.delim[1] <= cfg_data;
        dtt_pkg::REG_DELIM_C:     cfg.delim[2] <= cfg_data;
        dtt_pkg::REG_DELIM_D:     cfg.delim[3] <= cfg_data;
        dtt_pkg::REG_DELIM_COUNT: cfg.count    <= cfg_data[dtt_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: refill in the same cycle the held byte is consumed.
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.char_byte <= s_tdata;
      in_item.is_final  <= s_tlast;
    end
  end

  dtt_token u_token (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid),
    .item       (in_item),
    .take       (take),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {res.token_length, res.token_start};
  assign m_tlast = res.string_end;
  assign m_tuser = {res.too_long, res.token_valid};

endmodule

// File: sim/tb_delimiter_tokenizer_trim_top.sv
// ----------------------------------------------------------------------------
// tb_delimiter_tokenizer_trim_top
// Self-checking bench for the delimiter tokenizer with space trimming.
// ----------------------------------------------------------------------------
// Strings go in one byte per word on the slave stream. A behavioral copy of
// the tokenizer predicts each token word as bytes are accepted, and the
// monitor compares every word taken from the master stream against the
// oldest prediction, field by field. The run covers a short directed set
// and random strings under several delimiter settings and pacing modes.
// ----------------------------------------------------------------------------
module tb_delimiter_tokenizer_trim_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
  localparam int SETTLE_CYCLES = 8;     // input and result registers plus margin

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] char_byte
  logic        s_tlast  = 1'b0; // is_final

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [15:0] token_start, [31:16] token_length
  logic        m_tlast;         // string_end
  logic [1:0]  m_tuser;         // [0] token_valid, [1] too_long

  delimiter_tokenizer_trim_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bytes waiting for the driver, and token words the block still owes.
  dtt_pkg::item_t   pending_bytes[$];
  dtt_pkg::result_t tokens_due[$];
  int               mismatch_count = 0;

  // Pacing, in percent per cycle.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  // Shadow of the delimiter registers, updated on every write.
  logic [7:0] delim_byte [dtt_pkg::DELIM_SLOTS];
  logic [2:0] delim_num;

  // Tokenizer state of the predictor.
  int unsigned cur_pos;
  int unsigned tok_first;
  int unsigned tok_after;
  bit          tok_open;
  bit          str_over;

  always @(posedge clk) begin
    if (rst) begin
      delim_byte[0] <= dtt_pkg::DELIM_A_RESET;
      delim_byte[1] <= dtt_pkg::DELIM_OTHER_RESET;
      delim_byte[2] <= dtt_pkg::DELIM_OTHER_RESET;
      delim_byte[3] <= dtt_pkg::DELIM_OTHER_RESET;
      delim_num     <= dtt_pkg::DELIM_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (dtt_pkg::cfg_reg_t'(cfg_index))
        dtt_pkg::REG_DELIM_A:     delim_byte[0] <= cfg_data;
        dtt_pkg::REG_DELIM_B:     delim_byte[1] <= cfg_data;
        dtt_pkg::REG_DELIM_C:     delim_byte[2] <= cfg_data;
        dtt_pkg::REG_DELIM_D:     delim_byte[3] <= cfg_data;
        dtt_pkg::REG_DELIM_COUNT: delim_num     <= cfg_data[dtt_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Only the first delim_num slots count; anything above four acts as four.
  function automatic bit is_separator(logic [7:0] ch);
    int n;
    n = (delim_num > 3'd4) ? 4 : int'(delim_num);
    for (int i = 0; i < n; i++)
      if (ch == delim_byte[i]) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the predictor by one accepted byte; queue the word it causes.
  task automatic tokenize_byte(input logic [7:0] ch, input logic fin);
    dtt_pkg::result_t word;
    bit               closed;
    int unsigned      cs;
    int unsigned      cl;
    closed = 1'b0;
    cs     = 0;
    cl     = 0;
    if (cur_pos >= dtt_pkg::MAX_LENGTH) begin
      // past the limit the byte is dropped, only the flag moves
      str_over = 1'b1;
    end else begin
      if (is_separator(ch)) begin
        if (tok_open) begin
          closed   = 1'b1;
          cs       = tok_first;
          cl       = tok_after - tok_first;
          tok_open = 1'b0;
        end
      end else if (ch != dtt_pkg::SPACE_BYTE && delim_num != 0) begin
        if (!tok_open) begin
          tok_first = cur_pos;
          tok_open  = 1'b1;
        end
        tok_after = cur_pos + 1;
      end
      cur_pos++;
    end
    // the last byte flushes an open token
    if (fin && !closed && tok_open) begin
      closed   = 1'b1;
      cs       = tok_first;
      cl       = tok_after - tok_first;
      tok_open = 1'b0;
    end
    if (closed || fin) begin
      word.token_valid  = closed;
      word.token_start  = closed ? dtt_pkg::POS_W'(cs) : '0;
      word.token_length = closed ? dtt_pkg::POS_W'(cl) : '0;
      word.string_end   = fin;
      word.too_long     = str_over;
      tokens_due.push_back(word);
    end
    if (fin) begin
      cur_pos   = 0;
      tok_first = 0;
      tok_after = 0;
      tok_open  = 1'b0;
      str_over  = 1'b0;
    end
  endtask

  // Driver: predict on every accepted word, then offer the next byte unless
  // the sender idles this cycle. Hold the word while the block stalls.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      cur_pos   = 0;
      tok_first = 0;
      tok_after = 0;
      tok_open  = 1'b0;
      str_over  = 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        tokenize_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_bytes[0].char_byte;
          s_tlast  <= pending_bytes[0].is_final;
          void'(pending_bytes.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: compare each taken word with the oldest prediction, then pick
  // the next cycle's ready according to the stall rate.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tokens_due.size() == 0) begin
          $error("token word with nothing predicted: tdata %h tlast %b tuser %b",
                 m_tdata, m_tlast, m_tuser);
          mismatch_count++;
        end else begin
          check_field("token_valid",  tokens_due[0].token_valid,  m_tuser[0]);
          check_field("token_start",  tokens_due[0].token_start,  m_tdata[15:0]);
          check_field("token_length", tokens_due[0].token_length, m_tdata[31:16]);
          check_field("string_end",   tokens_due[0].string_end,   m_tlast);
          check_field("too_long",     tokens_due[0].too_long,     m_tuser[1]);
          void'(tokens_due.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic fin);
    dtt_pkg::item_t it;
    it.char_byte = ch;
    it.is_final  = fin;
    pending_bytes.push_back(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic write_reg(input dtt_pkg::cfg_reg_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // Write every register; call only while the block is idle.
  task automatic set_delims(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [7:0] d,
                            input logic [2:0] n);
    write_reg(dtt_pkg::REG_DELIM_A, a);
    write_reg(dtt_pkg::REG_DELIM_B, b);
    write_reg(dtt_pkg::REG_DELIM_C, c);
    write_reg(dtt_pkg::REG_DELIM_D, d);
    write_reg(dtt_pkg::REG_DELIM_COUNT, 8'(n));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drain: all bytes taken, all words seen, then let the pipe settle since
  // the last bytes may have caused no word at all.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_tvalid || tokens_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly tidy strings: configured delimiters (unused slots too) and spaces
  // around random bytes. The rest is raw noise. Lengths stay short.
  task automatic send_random_string(output int len);
    bit         tidy;
    int         r;
    logic [7:0] ch;
    len  = ($urandom_range(9) == 0) ? int'($urandom_range(200, 25))
                                    : int'($urandom_range(24, 1));
    tidy = ($urandom_range(9) < 7);
    for (int i = 0; i < len; i++) begin
      r = int'($urandom_range(99));
      if (tidy && r < 20)
        ch = delim_byte[$urandom_range(dtt_pkg::DELIM_SLOTS-1)];
      else if (tidy && r < 40)
        ch = dtt_pkg::SPACE_BYTE;
      else
        ch = 8'($urandom_range(255));
      send_byte(ch, i == len - 1);
    end
  endtask

  initial begin
    int         phase_len;
    int         len;
    logic [7:0] da, db, dc, dd;
    logic [2:0] dn;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset setting (comma only). Cover a token with inner
    // spaces, an empty piece, a final byte with nothing open, a final byte
    // that is itself a delimiter, and the extreme byte values.
    send_text(" a b , ,c ");
    send_text(",");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text(" ");
    wait_idle();

    // Count above four acts as four, and a space can be a delimiter.
    set_delims(",", ";", dtt_pkg::SPACE_BYTE, 8'hFF, 3'd7);
    send_text("x;y z");
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // Empty delimiter set: only the end-of-string word comes out.
    set_delims(",", ";", dtt_pkg::SPACE_BYTE, 8'hFF, 3'd0);
    send_text("ab,c");
    wait_idle();

    // Random phases; rotate pacing through none, sender idle, receiver
    // stall and both, and step the setting through its extremes.
    for (int phase = 0; phase < 8; phase++) begin
      unique case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
        default: begin src_idle_pct = 32; snk_stall_pct = 32; end
      endcase
      da = 8'($urandom_range(255));
      db = 8'($urandom_range(255));
      dc = 8'($urandom_range(255));
      dd = 8'($urandom_range(255));
      dn = 3'($urandom_range(7));
      unique case (phase)
        0: begin da = 8'h00; db = 8'h00; dc = 8'h00; dd = 8'h00; dn = 3'd4; end
        1: begin da = 8'hFF; db = 8'hFF; dc = 8'hFF; dd = 8'hFF; dn = 3'd7; end
        2: dn = 3'd0;
        3: begin da = dtt_pkg::SPACE_BYTE; dn = 3'($urandom_range(4, 1)); end
        default: ;
      endcase
      set_delims(da, db, dc, dd, dn);
      phase_len = 0;
      while (phase_len < 250) begin
        send_random_string(len);
        phase_len += len;
      end
      wait_idle();
    end

    if (mismatch_count == 0 && tokens_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (tokens_due.size() != 0)
        $error("%0d predicted token words never arrived", tokens_due.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
